// File: rtl/spwpc_pkg.sv
// package: widths, constants, item types and the arctangent table of the controller
`default_nettype none
package spwpc_pkg;

  // trig precision and derived widths
  localparam int TRIG_BITS = 16;
  localparam int TRIG_W    = TRIG_BITS + 3;
  localparam int ITER_W    = $clog2(TRIG_BITS);
  localparam int Z_W       = 33;
  localparam int POS_W     = 16;
  localparam int DIFF_W    = 18;
  localparam int ERR_W     = 22;
  localparam int GAIN_W    = 16;
  localparam int TOL_W     = 15;
  localparam int SIDE_W    = 14;
  localparam int UP_W      = 15;
  localparam int MUL_A_W   = ERR_W;
  localparam int MUL_B_W   = (TRIG_W > GAIN_W + 1) ? TRIG_W : GAIN_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = PROD_W + 1;

  // start value of the rotation, scaled cordic gain
  localparam longint unsigned TRIG_X0 =
    (64'd2608131496 + (64'd1 << (31 - TRIG_BITS))) >> (32 - TRIG_BITS);

  // phases
  localparam int PHASE_W = 4;
  localparam logic [PHASE_W-1:0] PH_STAND = 4'd0;
  localparam logic [PHASE_W-1:0] PH_FIRST = 4'd1;
  localparam logic [PHASE_W-1:0] PH_DONE  = 4'd9;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FWD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_TURN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_POS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_LAT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STAND     = 3'd5;

  localparam logic [GAIN_W-1:0] RST_GAIN_FWD  = 16'd26214;
  localparam logic [GAIN_W-1:0] RST_GAIN_TURN = 16'd13107;
  localparam logic [TOL_W-1:0]  RST_TOL_POS   = 15'd205;
  localparam logic [TOL_W-1:0]  RST_TOL_LAT   = 15'd410;
  localparam logic [SIDE_W-1:0] RST_SIDE      = 14'd4096;
  localparam logic [UP_W-1:0]   RST_STAND     = 15'd819;

  // item payloads
  typedef struct packed {
    logic                    mode;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]   cmd_forward;
    logic signed [15:0]   cmd_left;
    logic [UP_W-1:0]      cmd_up;
    logic                 special_cmd;
    logic                 standup_cmd;
    logic [PHASE_W-1:0]   phase_out;
    logic                 last;
  } out_item_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_POSE,
    OP_TRIG_INIT,
    OP_TRIG_STEP,
    OP_PROD_CA,
    OP_PROD_SA,
    OP_PROD_CL,
    OP_PROD_SL,
    OP_GAIN_F,
    OP_GAIN_L,
    OP_EMIT_STAND,
    OP_EMIT_DONE,
    OP_EMIT_CMD,
    OP_EMIT_STOP
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [ITER_W-1:0]   iter;
    logic [PHASE_W-1:0]  phase;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic out_space;
  } status_t;

  // arctangent of 2^-i, 2^32 equals a full turn
  function automatic logic signed [Z_W-1:0] atan_val(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = 33'sd536870912;
      5'd1:  v = 33'sd316933406;
      5'd2:  v = 33'sd167458907;
      5'd3:  v = 33'sd85004756;
      5'd4:  v = 33'sd42667331;
      5'd5:  v = 33'sd21354465;
      5'd6:  v = 33'sd10679838;
      5'd7:  v = 33'sd5340245;
      5'd8:  v = 33'sd2670163;
      5'd9:  v = 33'sd1335087;
      5'd10: v = 33'sd667544;
      5'd11: v = 33'sd333772;
      5'd12: v = 33'sd166886;
      5'd13: v = 33'sd83443;
      5'd14: v = 33'sd41722;
      5'd15: v = 33'sd20861;
      5'd16: v = 33'sd10430;
      5'd17: v = 33'sd5215;
      5'd18: v = 33'sd2608;
      5'd19: v = 33'sd1304;
      5'd20: v = 33'sd652;
      5'd21: v = 33'sd326;
      5'd22: v = 33'sd163;
      5'd23: v = 33'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/spwpc_if.sv
// interfaces: valid/ready channels for input and result items
`default_nettype none
interface spwpc_in_if;
  logic                 valid;
  logic                 ready;
  spwpc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spwpc_out_if;
  logic                 valid;
  logic                 ready;
  spwpc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/spwpc_dp.sv
// datapath: pose and config registers, cordic unit, shared multiplier, result register
`default_nettype none
module spwpc_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire spwpc_pkg::cmd_t                     cmd_i,
  output spwpc_pkg::status_t                       sts_o,
  input  wire spwpc_pkg::in_item_t                 in_data_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [spwpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [spwpc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output spwpc_pkg::out_item_t                     out_data_o
);

  localparam int TB = spwpc_pkg::TRIG_BITS;
  localparam int TW = spwpc_pkg::TRIG_W;
  localparam int ZW = spwpc_pkg::Z_W;
  localparam int DW = spwpc_pkg::DIFF_W;
  localparam int EW = spwpc_pkg::ERR_W;
  localparam int AW = spwpc_pkg::MUL_A_W;
  localparam int BW = spwpc_pkg::MUL_B_W;
  localparam int PW = spwpc_pkg::PROD_W;
  localparam int CW = spwpc_pkg::ACC_W;
  localparam int GW = spwpc_pkg::GAIN_W;
  localparam int RW = CW - 16;

  // configuration registers
  logic [GW-1:0]                     gain_fwd_q, gain_turn_q;
  logic [spwpc_pkg::TOL_W-1:0]       tol_pos_q, tol_lat_q;
  logic [spwpc_pkg::SIDE_W-1:0]      side_q;
  logic [spwpc_pkg::UP_W-1:0]        stand_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_fwd_q  <= spwpc_pkg::RST_GAIN_FWD;
      gain_turn_q <= spwpc_pkg::RST_GAIN_TURN;
      tol_pos_q   <= spwpc_pkg::RST_TOL_POS;
      tol_lat_q   <= spwpc_pkg::RST_TOL_LAT;
      side_q      <= spwpc_pkg::RST_SIDE;
      stand_q     <= spwpc_pkg::RST_STAND;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spwpc_pkg::CFG_GAIN_FWD:  gain_fwd_q  <= cfg_data_i[GW-1:0];
        spwpc_pkg::CFG_GAIN_TURN: gain_turn_q <= cfg_data_i[GW-1:0];
        spwpc_pkg::CFG_TOL_POS:   tol_pos_q   <= cfg_data_i[spwpc_pkg::TOL_W-1:0];
        spwpc_pkg::CFG_TOL_LAT:   tol_lat_q   <= cfg_data_i[spwpc_pkg::TOL_W-1:0];
        spwpc_pkg::CFG_SIDE:      side_q      <= cfg_data_i[spwpc_pkg::SIDE_W-1:0];
        spwpc_pkg::CFG_STAND:     stand_q     <= cfg_data_i[spwpc_pkg::UP_W-1:0];
        default: ;
      endcase
    end
  end

  // pose and origin
  logic signed [spwpc_pkg::POS_W-1:0] cur_x_q, cur_y_q, org_x_q, org_y_q;
  logic [spwpc_pkg::POS_W-1:0]        head_q;
  logic                               have_org_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      head_q     <= '0;
      org_x_q    <= '0;
      org_y_q    <= '0;
      have_org_q <= 1'b0;
    end else if (cmd_i.op == spwpc_pkg::OP_POSE) begin
      cur_x_q <= in_data_i.pos_x;
      cur_y_q <= in_data_i.pos_y;
      head_q  <= in_data_i.heading;
      if (!have_org_q) begin
        org_x_q    <= in_data_i.pos_x;
        org_y_q    <= in_data_i.pos_y;
        have_org_q <= 1'b1;
      end
    end
  end

  // corners of the current leg and the position differences
  logic [1:0]           leg, tgt;
  logic                 rotate;
  logic signed [DW-1:0] side_s, ox, oy, sx, sy, tx, ty, cx, cy;
  logic signed [DW-1:0] ax, ay, lx, ly;

  always_comb begin
    leg    = 2'((cmd_i.phase - spwpc_pkg::PH_FIRST) >> 1);
    tgt    = leg + 2'd1;
    rotate = cmd_i.phase[0];
    side_s = DW'($signed({1'b0, side_q}));
    ox     = DW'(org_x_q);
    oy     = DW'(org_y_q);
    cx     = DW'(cur_x_q);
    cy     = DW'(cur_y_q);
    sx     = ox + ((leg == 2'd1 || leg == 2'd2) ? side_s : '0);
    sy     = oy + (leg[1] ? side_s : '0);
    tx     = ox + ((tgt == 2'd1 || tgt == 2'd2) ? side_s : '0);
    ty     = oy + (tgt[1] ? side_s : '0);
    ax     = (rotate ? sx : tx) - cx;
    ay     = (rotate ? sy : ty) - cy;
    lx     = tx - cx;
    ly     = ty - cy;
  end

  // cordic rotation, one step a cycle
  logic signed [TW-1:0] x_q, y_q, xs, ys;
  logic signed [ZW-1:0] z_q, z_init;
  logic                 neg_q, neg_init;
  logic [15:0]          head_b;
  logic signed [TW-1:0] cos_v, sin_v;

  always_comb begin
    head_b   = head_q + 16'h4000;
    neg_init = head_b[15];
    z_init   = ZW'($signed({head_q ^ {neg_init, 15'b0}, 16'b0}));
    xs       = x_q >>> cmd_i.iter;
    ys       = y_q >>> cmd_i.iter;
    cos_v    = neg_q ? -x_q : x_q;
    sin_v    = neg_q ? -y_q : y_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == spwpc_pkg::OP_TRIG_INIT) begin
      x_q   <= TW'(spwpc_pkg::TRIG_X0);
      y_q   <= '0;
      z_q   <= z_init;
      neg_q <= neg_init;
    end else if (cmd_i.op == spwpc_pkg::OP_TRIG_STEP) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - spwpc_pkg::atan_val(5'(cmd_i.iter));
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + spwpc_pkg::atan_val(5'(cmd_i.iter));
      end
    end
  end

  // shared multiplier and error / command arithmetic
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [CW-1:0] acc_q, sum_along, sum_lat, sum_gain;
  logic signed [EW-1:0] along_q, lat_q;
  logic signed [RW-1:0] rnd_gain;
  logic signed [15:0]   fwd_q, left_q, sat_v;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      spwpc_pkg::OP_PROD_CA: begin mul_a = AW'(ax); mul_b = BW'(cos_v); end
      spwpc_pkg::OP_PROD_SA: begin mul_a = AW'(ay); mul_b = BW'(sin_v); end
      spwpc_pkg::OP_PROD_CL: begin mul_a = AW'(ly); mul_b = BW'(cos_v); end
      spwpc_pkg::OP_PROD_SL: begin mul_a = AW'(lx); mul_b = BW'(sin_v); end
      spwpc_pkg::OP_GAIN_F: begin
        mul_a = AW'(along_q);
        mul_b = BW'($signed({1'b0, gain_fwd_q}));
      end
      spwpc_pkg::OP_GAIN_L: begin
        mul_a = AW'(lat_q);
        mul_b = BW'($signed({1'b0, gain_turn_q}));
      end
      default: ;
    endcase
    prod      = mul_a * mul_b;
    sum_along = acc_q + CW'(prod) + (CW'(1) <<< (TB - 1));
    sum_lat   = acc_q - CW'(prod) + (CW'(1) <<< (TB - 1));
    sum_gain  = CW'(prod) + (CW'(1) <<< 15);
    rnd_gain  = RW'(sum_gain >>> 16);
    if (rnd_gain > RW'(32767))       sat_v = 16'sh7fff;
    else if (rnd_gain < -RW'(32768)) sat_v = -16'sh8000;
    else                             sat_v = 16'(rnd_gain);
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      spwpc_pkg::OP_PROD_CA, spwpc_pkg::OP_PROD_CL: acc_q <= CW'(prod);
      spwpc_pkg::OP_PROD_SA: along_q <= EW'(sum_along >>> TB);
      spwpc_pkg::OP_PROD_SL: lat_q   <= EW'(sum_lat >>> TB);
      spwpc_pkg::OP_GAIN_F:  fwd_q   <= sat_v;
      spwpc_pkg::OP_GAIN_L:  left_q  <= sat_v;
      default: ;
    endcase
  end

  // tolerance check
  logic signed [EW:0] abs_along, abs_lat;

  always_comb begin
    abs_along     = along_q[EW-1] ? -(EW+1)'(along_q) : (EW+1)'(along_q);
    abs_lat       = lat_q[EW-1] ? -(EW+1)'(lat_q) : (EW+1)'(lat_q);
    sts_o.ok      = (abs_along <= (EW+1)'($signed({1'b0, tol_pos_q}))) &&
                    (abs_lat <= (EW+1)'($signed({1'b0, tol_lat_q})));
    sts_o.out_space = !out_valid_o || out_ready_i;
  end

  // result register
  logic                 out_valid_q;
  spwpc_pkg::out_item_t out_q, out_d;
  logic                 emit;

  always_comb begin
    emit = (cmd_i.op == spwpc_pkg::OP_EMIT_STAND) || (cmd_i.op == spwpc_pkg::OP_EMIT_DONE) ||
           (cmd_i.op == spwpc_pkg::OP_EMIT_CMD) || (cmd_i.op == spwpc_pkg::OP_EMIT_STOP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // next result item, a stop command unless the operation says otherwise
  always_comb begin
    out_d.phase_out   = cmd_i.phase;
    out_d.cmd_forward = '0;
    out_d.cmd_left    = '0;
    out_d.cmd_up      = stand_q;
    out_d.special_cmd = 1'b0;
    out_d.standup_cmd = 1'b0;
    out_d.last        = 1'b1;
    case (cmd_i.op)
      spwpc_pkg::OP_EMIT_STAND: begin
        out_d.special_cmd = 1'b1;
        out_d.standup_cmd = 1'b1;
      end
      spwpc_pkg::OP_EMIT_DONE: begin
        out_d.cmd_up      = '0;
        out_d.special_cmd = 1'b1;
      end
      spwpc_pkg::OP_EMIT_CMD: begin
        out_d.cmd_forward = fwd_q;
        out_d.cmd_left    = left_q;
        out_d.last        = !sts_o.ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: rtl/spwpc_ctrl.sv
// controller: phase program and sequencing of the datapath
`default_nettype none
module spwpc_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_mode_i,
  output logic                            in_ready_o,
  input  wire spwpc_pkg::status_t         sts_i,
  output spwpc_pkg::cmd_t                 cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_TRIG      = 11'b000_0000_0010,
    S_PCA       = 11'b000_0000_0100,
    S_PSA       = 11'b000_0000_1000,
    S_PCL       = 11'b000_0001_0000,
    S_PSL       = 11'b000_0010_0000,
    S_GF        = 11'b000_0100_0000,
    S_GL        = 11'b000_1000_0000,
    S_EMIT_CMD  = 11'b001_0000_0000,
    S_EMIT_STOP = 11'b010_0000_0000,
    S_EMIT_FIX  = 11'b100_0000_0000
  } state_e;

  state_e                               state_q, state_d;
  logic [spwpc_pkg::PHASE_W-1:0]        phase_q, phase_d;
  logic [spwpc_pkg::ITER_W-1:0]         iter_q, iter_d;
  spwpc_pkg::op_e                       op;

  // next state and datapath operation
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    iter_d     = iter_q;
    op         = spwpc_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!in_mode_i) begin
            op = spwpc_pkg::OP_POSE;
          end else begin
            op     = spwpc_pkg::OP_TRIG_INIT;
            iter_d = '0;
            if (phase_q == spwpc_pkg::PH_STAND || phase_q >= spwpc_pkg::PH_DONE) begin
              state_d = S_EMIT_FIX;
            end else begin
              state_d = S_TRIG;
            end
          end
        end
      end
      S_TRIG: begin
        op     = spwpc_pkg::OP_TRIG_STEP;
        iter_d = iter_q + 1'b1;
        if (iter_q == spwpc_pkg::ITER_W'(spwpc_pkg::TRIG_BITS - 1)) begin
          state_d = S_PCA;
        end
      end
      S_PCA: begin op = spwpc_pkg::OP_PROD_CA; state_d = S_PSA; end
      S_PSA: begin op = spwpc_pkg::OP_PROD_SA; state_d = S_PCL; end
      S_PCL: begin op = spwpc_pkg::OP_PROD_CL; state_d = S_PSL; end
      S_PSL: begin op = spwpc_pkg::OP_PROD_SL; state_d = S_GF; end
      S_GF:  begin op = spwpc_pkg::OP_GAIN_F;  state_d = S_GL; end
      S_GL:  begin op = spwpc_pkg::OP_GAIN_L;  state_d = S_EMIT_CMD; end
      S_EMIT_CMD: begin
        if (sts_i.out_space) begin
          op      = spwpc_pkg::OP_EMIT_CMD;
          state_d = sts_i.ok ? S_EMIT_STOP : S_IDLE;
        end
      end
      S_EMIT_STOP: begin
        if (sts_i.out_space) begin
          op      = spwpc_pkg::OP_EMIT_STOP;
          phase_d = phase_q + 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMIT_FIX: begin
        if (sts_i.out_space) begin
          state_d = S_IDLE;
          if (phase_q == spwpc_pkg::PH_STAND) begin
            op      = spwpc_pkg::OP_EMIT_STAND;
            phase_d = spwpc_pkg::PH_FIRST;
          end else begin
            op = spwpc_pkg::OP_EMIT_DONE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= spwpc_pkg::PH_STAND;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      iter_q  <= iter_d;
    end
  end

  assign cmd_o.op    = op;
  assign cmd_o.iter  = iter_q;
  assign cmd_o.phase = phase_q;

endmodule
`default_nettype wire

// File: rtl/square_path_waypoint_p_controller_core.sv
// Square-path waypoint controller: a pose item updates the pose and gives no result.
// A control tick in a move or rotate phase runs the cordic unit step by step and
// then the shared multiplier before its first result; a stop result follows when
// both errors are within tolerance. Stand-up and done ticks give a single result.
// Reset is asynchronous, active low, and returns the phase to stand-up, clears
// the pose and origin and reloads the gains.
`default_nettype none
module square_path_waypoint_p_controller_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  spwpc_in_if.sink                                 in_chan,
  spwpc_out_if.source                              out_chan,
  input  wire logic                                cfg_we_i,
  input  wire logic [spwpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [spwpc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  spwpc_pkg::cmd_t    cmd;
  spwpc_pkg::status_t sts;

  // sequencer
  spwpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_mode_i  (in_chan.data.mode),
    .in_ready_o (in_chan.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  spwpc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_chan.data),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_chan.valid),
    .out_ready_i (out_chan.ready),
    .out_data_o  (out_chan.data)
  );

endmodule
`default_nettype wire
